// ===== rtl/md5_pkg.sv =====
// Package: MD5 constants, round tables, controller states and core control bundle.
`default_nettype none

package md5_pkg;

    localparam int WORD_WIDTH  = 32;
    localparam int BUF_DEPTH   = 16;
    localparam int COUNT_WIDTH = 61;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_MARKER  = 8'h80;
    localparam logic [5:0] PAD_LIMIT   = 6'd56;
    localparam logic [5:0] BLOCK_LAST  = 6'd63;
    localparam logic [3:0] LEN_WORD_LO = 4'd14;
    localparam logic [3:0] LEN_WORD_HI = 4'd15;
    localparam logic [3:0] WORD_LAST   = 4'd15;
    localparam logic [5:0] ROUND_LAST  = 6'd63;
    localparam logic [1:0] DIGEST_LAST = 2'd3;

    localparam logic CMD_DATA   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_PRIME,
        S_ROUND,
        S_FOLD,
        S_OUT
    } md5_state_t;

    typedef struct packed {
        logic       load;
        logic       round;
        logic       fold;
        logic       reinit;
        logic [5:0] rnd;
        logic [1:0] sel;
    } core_ctrl_t;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] j;
        logic [3:0] g;
        j = i[3:0];
        unique case (i[5:4])
            2'd0:    g = j;
            2'd1:    g = j + (j << 2) + 4'd1;
            2'd2:    g = j + (j << 1) + 4'd5;
            default: g = (j << 3) - j;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/md5_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/md5_core.sv =====
// MD5 round datapath: working variables, one round per cycle, chaining words.
`default_nettype none

module md5_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire md5_pkg::core_ctrl_t ctrl,
    input  wire logic [31:0]        w_word,
    output logic      [31:0]        chain_word
);

    import md5_pkg::*;

    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] chain_reg [4];
    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] dbl;
    logic [31:0] b_next;

    always_comb
    begin
        unique case (ctrl.rnd[5:4])
            2'd0:    f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum    = a_reg + f + round_const(ctrl.rnd) + w_word;
        dbl    = {sum, sum} << rot_amount(ctrl.rnd);
        b_next = b_reg + dbl[63:32];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (ctrl.round)
        begin
            a_reg <= d_reg;
            b_reg <= b_next;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
        end
        else if (ctrl.reinit)
        begin
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
        end
        else if (ctrl.fold)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
        end
    end

    assign chain_word = chain_reg[ctrl.sel];

endmodule

`default_nettype wire

// ===== rtl/md5_message_digest_top.sv =====
// Top level: MD5 message digest, byte stream in, four digest words out.
//
// Input channel s_axis: one transaction per item. tuser[0] is the command
// (0 = append the byte in tdata, 1 = finish the message). Output channel
// m_axis: four transactions per finish, words A, B, C, D with tuser giving
// the word index and tlast marking word D.
// Bytes are taken back to back while idle. The 64-byte block buffer lives
// in a 16 x 32 RAM with registered read data; the byte that completes a
// block starts a compression (read priming, 64 rounds through a single
// round unit, a fold), during which s_axis_tready is low. A finish writes
// padding words p/4 to 15 (p = bytes in the block) and compresses the
// block; when p >= 56 a second block of 16 pad words and its compression
// follow. The digest words are offered one per cycle while m_axis_tready
// is high; while the receiver stalls, the word on m_axis holds and no
// input is taken. After word D the chaining words, byte counters and
// block position return to their initial values. Reset puts the block in
// the same state: idle, ready for the first byte of a message.
`default_nettype none

module md5_message_digest_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic      [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic             m_axis_tlast    // last_word
);

    import md5_pkg::*;

    md5_state_t       state_reg, state_next;
    logic [5:0]       bib_reg, bib_next;
    logic [60:0]      count_reg, count_next;
    logic [23:0]      pend_reg, pend_next;
    logic [3:0]       wptr_reg, wptr_next;
    logic [5:0]       rnd_reg, rnd_next;
    logic [1:0]       sel_reg, sel_next;
    logic             finishing_reg, finishing_next;
    logic             marker_done_reg, marker_done_next;
    logic             final_reg, final_next;

    logic             in_accept;
    logic             out_accept;
    logic             len_now;
    logic [63:0]      bits;
    logic [31:0]      pad_word;
    logic             ram_we;
    logic [3:0]       ram_waddr;
    logic [31:0]      ram_wdata;
    logic [3:0]       ram_raddr;
    logic [31:0]      ram_rdata;
    core_ctrl_t       ctrl;
    logic [31:0]      chain_word;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;
    assign len_now    = marker_done_reg || (bib_reg < PAD_LIMIT);
    assign bits       = {count_reg, 3'b000};

    always_comb
    begin
        pad_word = '0;
        if (!marker_done_reg && wptr_reg == bib_reg[5:2])
        begin
            case (bib_reg[1:0])
                2'd0:    pad_word = {24'd0, PAD_MARKER};
                2'd1:    pad_word = {16'd0, PAD_MARKER, pend_reg[7:0]};
                2'd2:    pad_word = {8'd0, PAD_MARKER, pend_reg[15:0]};
                default: pad_word = {PAD_MARKER, pend_reg};
            endcase
        end
        else if (len_now && wptr_reg == LEN_WORD_LO)
        begin
            pad_word = bits[31:0];
        end
        else if (len_now && wptr_reg == LEN_WORD_HI)
        begin
            pad_word = bits[63:32];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser[0] == CMD_FINISH)
                    begin
                        state_next = S_PAD;
                    end
                    else if (bib_reg == BLOCK_LAST)
                    begin
                        state_next = S_PRIME;
                    end
                end
            end
            S_PAD:
            begin
                if (wptr_reg == WORD_LAST)
                begin
                    state_next = S_PRIME;
                end
            end
            S_PRIME:
            begin
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (rnd_reg == ROUND_LAST)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                if (!finishing_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (final_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_PAD;
                end
            end
            S_OUT:
            begin
                if (out_accept && sel_reg == DIGEST_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = bib_reg[5:2];
        ram_wdata     = {s_axis_tdata, pend_reg};
        ram_raddr     = msg_index(rnd_reg + 6'd1);
        ctrl          = '0;
        ctrl.rnd      = rnd_reg;
        ctrl.sel      = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                ram_we = in_accept && s_axis_tuser[0] == CMD_DATA && bib_reg[1:0] == 2'd3;
            end
            S_PAD:
            begin
                ram_we    = 1'b1;
                ram_waddr = wptr_reg;
                ram_wdata = pad_word;
            end
            S_PRIME:
            begin
                ram_raddr = msg_index(6'd0);
                ctrl.load = 1'b1;
            end
            S_ROUND:
            begin
                ctrl.round = 1'b1;
            end
            S_FOLD:
            begin
                ctrl.fold = 1'b1;
            end
            S_OUT:
            begin
                m_axis_tvalid = 1'b1;
                ctrl.reinit   = out_accept && sel_reg == DIGEST_LAST;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        bib_next         = bib_reg;
        count_next       = count_reg;
        pend_next        = pend_reg;
        wptr_next        = wptr_reg;
        rnd_next         = rnd_reg;
        sel_next         = sel_reg;
        finishing_next   = finishing_reg;
        marker_done_next = marker_done_reg;
        final_next       = final_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && s_axis_tuser[0] == CMD_DATA)
                begin
                    case (bib_reg[1:0])
                        2'd0:    pend_next[7:0]   = s_axis_tdata;
                        2'd1:    pend_next[15:8]  = s_axis_tdata;
                        2'd2:    pend_next[23:16] = s_axis_tdata;
                        default: pend_next        = pend_reg;
                    endcase
                    bib_next       = bib_reg + 6'd1;
                    count_next     = count_reg + 61'd1;
                    finishing_next = 1'b0;
                end
                else if (in_accept)
                begin
                    wptr_next        = bib_reg[5:2];
                    marker_done_next = 1'b0;
                    finishing_next   = 1'b1;
                end
            end
            S_PAD:
            begin
                wptr_next = wptr_reg + 4'd1;
                if (wptr_reg == WORD_LAST)
                begin
                    final_next       = len_now;
                    marker_done_next = 1'b1;
                end
            end
            S_PRIME:
            begin
                rnd_next = '0;
            end
            S_ROUND:
            begin
                rnd_next = rnd_reg + 6'd1;
            end
            S_FOLD:
            begin
                wptr_next = '0;
                sel_next  = '0;
            end
            S_OUT:
            begin
                if (out_accept)
                begin
                    sel_next = sel_reg + 2'd1;
                    if (sel_reg == DIGEST_LAST)
                    begin
                        bib_next       = '0;
                        count_next     = '0;
                        finishing_next = 1'b0;
                    end
                end
            end
            default:
            begin
                bib_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            bib_reg         <= '0;
            count_reg       <= '0;
            wptr_reg        <= '0;
            rnd_reg         <= '0;
            sel_reg         <= '0;
            finishing_reg   <= 1'b0;
            marker_done_reg <= 1'b0;
            final_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            bib_reg         <= bib_next;
            count_reg       <= count_next;
            wptr_reg        <= wptr_next;
            rnd_reg         <= rnd_next;
            sel_reg         <= sel_next;
            finishing_reg   <= finishing_next;
            marker_done_reg <= marker_done_next;
            final_reg       <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    md5_ram #(
        .WIDTH(WORD_WIDTH),
        .DEPTH(BUF_DEPTH)
    ) u_buf (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    md5_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .w_word    (ram_rdata),
        .chain_word(chain_word)
    );

    assign m_axis_tdata = chain_word;
    assign m_axis_tuser = sel_reg;
    assign m_axis_tlast = (sel_reg == DIGEST_LAST);

    a_no_write_in_compress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRIME || state_reg == S_ROUND) |-> !ram_we)
        else $error("block buffer written during compression");

    a_in_out_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while digest pending");

    a_full_block_compress: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tuser[0] == CMD_DATA && bib_reg == BLOCK_LAST)
        |=> (state_reg == S_PRIME && bib_reg == 6'd0))
        else $error("full block did not start compression");

    a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && m_axis_tlast)
        |=> (state_reg == S_IDLE && bib_reg == 6'd0 && count_reg == 61'd0))
        else $error("state not restored after digest");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the MD5 digest block: byte streams in, digest words checked against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import md5_pkg::CMD_DATA;
    import md5_pkg::CMD_FINISH;
    import md5_pkg::INIT_A;
    import md5_pkg::INIT_B;
    import md5_pkg::INIT_C;
    import md5_pkg::INIT_D;

    localparam int RANDOM_ITEMS  = 340;
    localparam int STALL_HOLD    = 400;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int SETTLE_CYCLES = 200;

    localparam logic [64*32-1:0] SINE_TABLE = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [16*5-1:0] SHIFT_TABLE = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic [0:0]  s_axis_tuser = CMD_DATA;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    logic [31:0] chain [4];
    logic [7:0]  block_bytes [64];
    int unsigned block_fill;
    logic [60:0] message_bytes;

    digest_word_t pending_words [$];
    int unsigned  error_count = 0;
    int unsigned  items_sent = 0;
    int unsigned  quiet_cycles = 0;
    bit           idling_on = 1'b1;
    bit           stall_request = 1'b0;

    md5_message_digest_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] rotate_left(input logic [31:0] x, input logic [4:0] s);
        return (x << s) | (x >> (6'd32 - s));
    endfunction

    function automatic void compress_block();
        logic [31:0] msg [16];
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] f;
        logic [31:0] held;
        int unsigned g;
        for (int i = 0; i < 16; i++)
        begin
            msg[i] = {block_bytes[4*i+3], block_bytes[4*i+2],
                      block_bytes[4*i+1], block_bytes[4*i]};
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0:       begin f = (b & c) | (~b & d); g = i;                 end
                1:       begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16;  end
                2:       begin f = b ^ c ^ d;          g = (3 * i + 5) % 16;  end
                default: begin f = c ^ (b | ~d);       g = (7 * i) % 16;      end
            endcase
            held = d;
            d = c;
            c = b;
            b = b + rotate_left(a + f + SINE_TABLE[(63 - i) * 32 +: 32] + msg[g],
                                SHIFT_TABLE[(15 - ((i / 16) * 4 + i % 4)) * 5 +: 5]);
            a = held;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endfunction

    function automatic void restart_message();
        chain[0] = INIT_A;
        chain[1] = INIT_B;
        chain[2] = INIT_C;
        chain[3] = INIT_D;
        block_fill = 0;
        message_bytes = '0;
    endfunction

    function automatic void absorb_item(input logic cmd, input logic [7:0] value);
        logic [63:0]  bit_length;
        digest_word_t entry;
        if (cmd == CMD_DATA)
        begin
            block_bytes[block_fill] = value;
            block_fill++;
            message_bytes++;
            if (block_fill == 64)
            begin
                compress_block();
                block_fill = 0;
            end
            return;
        end
        block_bytes[block_fill] = 8'h80;
        block_fill++;
        if (block_fill > 56)
        begin
            while (block_fill < 64)
            begin
                block_bytes[block_fill] = 8'h00;
                block_fill++;
            end
            compress_block();
            block_fill = 0;
        end
        while (block_fill < 56)
        begin
            block_bytes[block_fill] = 8'h00;
            block_fill++;
        end
        bit_length = {message_bytes, 3'b000};
        for (int k = 0; k < 8; k++)
        begin
            block_bytes[56 + k] = bit_length[8*k +: 8];
        end
        compress_block();
        for (int k = 0; k < 4; k++)
        begin
            entry.word  = chain[k];
            entry.index = k[1:0];
            entry.last  = (k == 3);
            pending_words.push_back(entry);
        end
        restart_message();
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idling_on)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            return 0;
        end
        if (roll < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 50);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            absorb_item(s_axis_tuser[0], s_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        digest_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word: actual %h idx %0d last %0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                error_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (m_axis_tdata !== want.word)
                begin
                    $display("%0t: digest word: expected %h actual %h",
                             $time, want.word, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== want.index)
                begin
                    $display("%0t: word index: expected %0d actual %0d",
                             $time, want.index, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: last word: expected %0b actual %0b",
                             $time, want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_MAX)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_MAX);
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int unsigned hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (stall_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (STALL_HOLD) @(posedge clk);
                stall_request = 1'b0;
            end
            else
            begin
                hold = pick_gap();
                if (hold == 0)
                begin
                    m_axis_tready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    repeat (hold) @(posedge clk);
                end
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] value);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_message(input int unsigned length);
        for (int unsigned i = 0; i < length; i++)
        begin
            send_item(CMD_DATA, 8'($urandom_range(0, 255)));
        end
        send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_for_digests();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed_messages();
        send_item(CMD_FINISH, 8'h00);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'hff);
        send_item(CMD_FINISH, 8'hff);
        send_item(CMD_DATA, 8'h61);
        send_item(CMD_DATA, 8'h62);
        send_item(CMD_DATA, 8'h63);
        send_item(CMD_FINISH, 8'h5a);
        send_item(CMD_FINISH, 8'ha5);
        send_item(CMD_FINISH, 8'h00);
        wait_for_digests();
    endtask

    task automatic test_output_stall();
        idling_on = 1'b0;
        stall_request = 1'b1;
        send_message(0);
        send_message(5);
        send_message(0);
        send_message(2);
        while (stall_request) @(posedge clk);
        wait_for_digests();
        idling_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        idling_on = 1'b0;
        send_message(56);
        send_message(0);
        send_message(3);
        idling_on = 1'b1;
    endtask

    task automatic test_random_messages();
        int unsigned roll;
        int unsigned length;
        int unsigned target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 6)
            begin
                length = $urandom_range(0, 12);
            end
            else if (roll < 9)
            begin
                case ($urandom_range(0, 6))
                    0:       length = 54;
                    1:       length = 55;
                    2:       length = 56;
                    3:       length = 57;
                    4:       length = 63;
                    5:       length = 64;
                    default: length = 65;
                endcase
            end
            else
            begin
                length = $urandom_range(100, 130);
            end
            idling_on = ($urandom_range(0, 4) != 0);
            send_message(length);
        end
        idling_on = 1'b1;
    endtask

    initial
    begin
        restart_message();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_messages();
        test_output_stall();
        test_back_to_back();
        test_random_messages();
        wait_for_digests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
